// ===== hw/rtl/i2crm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and codes for the register-access I2C master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  // request class decided by the front end
  typedef logic [1:0] req_kind_t;
  localparam req_kind_t REQ_TICK  = 2'd0;
  localparam req_kind_t REQ_WRITE = 2'd1;
  localparam req_kind_t REQ_READ  = 2'd2;

  // raw request codes on the input
  localparam logic [1:0] REQ_CODE_WRITE = 2'd1;
  localparam logic [1:0] REQ_CODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_HALF_PERIOD = 1'b0;
  localparam logic CFG_IDX_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    req_kind_t  kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_sel;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_owned;
    logic       busy_res;
    logic       finished;
    logic       status;
    logic [7:0] read_byte;
  } result_t;

endpackage

// ===== hw/rtl/i2crm_front.sv =====
// ----------------------------------------------------------------------------
// i2crm_front
// Accepts input beats, classifies the request and holds them in a
// two-entry queue for the bus engine.
// ----------------------------------------------------------------------------
module i2crm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [6:0]        in_dev_addr,
  input  logic [7:0]        in_reg_sel,
  input  logic [7:0]        in_write_data,
  input  logic              in_sda_in,
  input  logic              pop,
  output logic              q_valid,
  output i2crm_pkg::item_t  q_item
);

  i2crm_pkg::item_t  item;
  i2crm_pkg::item_t  queue_r [2];
  logic              wr_ptr_r;
  logic              wr_ptr_nxt;
  logic              rd_ptr_r;
  logic              rd_ptr_nxt;
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  logic              push;

  always_comb begin
    item.dev_addr   = in_dev_addr;
    item.reg_sel    = in_reg_sel;
    item.write_data = in_write_data;
    item.sda_in     = in_sda_in;
    case (in_req_type)
      i2crm_pkg::REQ_CODE_WRITE: item.kind = i2crm_pkg::REQ_WRITE;
      i2crm_pkg::REQ_CODE_READ:  item.kind = i2crm_pkg::REQ_READ;
      default:                   item.kind = i2crm_pkg::REQ_TICK;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/i2crm_back.sv =====
// ----------------------------------------------------------------------------
// i2crm_back
// Bus engine: advances the SCL/SDA sequencer one tick per queued beat and
// registers the resulting line levels and status.
// ----------------------------------------------------------------------------
module i2crm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  i2crm_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  i2crm_pkg::item_t  q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output i2crm_pkg::result_t res
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_TX_LO   = 4'd3;
  localparam logic [3:0] PH_TX_HI   = 4'd4;
  localparam logic [3:0] PH_TX_TL   = 4'd5;
  localparam logic [3:0] PH_AK_LO   = 4'd6;
  localparam logic [3:0] PH_AK_HI   = 4'd7;
  localparam logic [3:0] PH_AK_POLL = 4'd8;
  localparam logic [3:0] PH_AK_TL   = 4'd9;
  localparam logic [3:0] PH_RX_LO   = 4'd10;
  localparam logic [3:0] PH_RX_HI   = 4'd11;
  localparam logic [3:0] PH_NK_LO   = 4'd12;
  localparam logic [3:0] PH_NK_HI   = 4'd13;
  localparam logic [3:0] PH_SP_LO   = 4'd14;
  localparam logic [3:0] PH_SP_HI   = 4'd15;

  logic [3:0]  phase_r,    phase_nxt;
  logic [15:0] delay_r,    delay_nxt;
  logic [2:0]  bit_idx_r,  bit_idx_nxt;
  logic [7:0]  shift_r,    shift_nxt;
  logic [7:0]  ack_cnt_r,  ack_cnt_nxt;
  logic [6:0]  addr_r,     addr_nxt;
  logic [7:0]  reg_r,      reg_nxt;
  logic [7:0]  data_r,     data_nxt;
  logic        is_read_r,  is_read_nxt;
  logic [7:0]  rx_r,       rx_nxt;
  logic [1:0]  stage_r,    stage_nxt;
  logic        failed_r,   failed_nxt;
  logic        out_valid_r;
  i2crm_pkg::result_t res_r, res_nxt;

  logic [15:0] half;
  logic [15:0] delay_inc;
  logic [7:0]  rx_shift;
  logic [7:0]  stage_byte;
  logic        done;
  logic        bad;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign half      = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
  assign delay_inc = delay_r + 16'd1;
  assign rx_shift  = {shift_r[6:0], q_item.sda_in};

  // byte sent for the current stage
  always_comb begin
    case (stage_r)
      2'd0:    stage_byte = {addr_r, 1'b0};
      2'd1:    stage_byte = reg_r;
      default: stage_byte = is_read_r ? {addr_r, 1'b1} : data_r;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    delay_nxt   = delay_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    ack_cnt_nxt = ack_cnt_r;
    addr_nxt    = addr_r;
    reg_nxt     = reg_r;
    data_nxt    = data_r;
    is_read_nxt = is_read_r;
    rx_nxt      = rx_r;
    stage_nxt   = stage_r;
    failed_nxt  = failed_r;
    done        = 1'b0;
    bad         = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (q_item.kind == i2crm_pkg::REQ_WRITE || q_item.kind == i2crm_pkg::REQ_READ) begin
        addr_nxt    = q_item.dev_addr;
        reg_nxt     = q_item.reg_sel;
        data_nxt    = q_item.write_data;
        is_read_nxt = (q_item.kind == i2crm_pkg::REQ_READ);
        stage_nxt   = 2'd0;
        failed_nxt  = 1'b0;
        delay_nxt   = 16'd0;
        phase_nxt   = PH_ST_A;
      end
    end else if (phase_r == PH_AK_POLL) begin
      if (!q_item.sda_in) begin
        delay_nxt = 16'd0;
        phase_nxt = PH_AK_TL;
      end else if (ack_cnt_r >= cfg.ack_timeout) begin
        failed_nxt = 1'b1;
        delay_nxt  = 16'd0;
        phase_nxt  = PH_SP_LO;
      end else begin
        ack_cnt_nxt = ack_cnt_r + 8'd1;
      end
    end else if (delay_inc >= half) begin
      delay_nxt = 16'd0;
      case (phase_r)
        PH_ST_A:  phase_nxt = PH_ST_B;
        PH_ST_B: begin
          shift_nxt   = stage_byte;
          bit_idx_nxt = 3'd0;
          phase_nxt   = PH_TX_LO;
        end
        PH_TX_LO: phase_nxt = PH_TX_HI;
        PH_TX_HI: phase_nxt = PH_TX_TL;
        PH_TX_TL: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_idx_r == 3'd7) begin
            ack_cnt_nxt = 8'd0;
            phase_nxt   = PH_AK_LO;
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            phase_nxt   = PH_TX_LO;
          end
        end
        PH_AK_LO: phase_nxt = PH_AK_HI;
        PH_AK_HI: phase_nxt = PH_AK_POLL;
        PH_AK_TL: begin
          bit_idx_nxt = 3'd0;
          if (stage_r == 2'd0) begin
            stage_nxt = 2'd1;
            shift_nxt = reg_r;
            phase_nxt = PH_TX_LO;
          end else if (stage_r == 2'd1) begin
            stage_nxt = 2'd2;
            if (is_read_r) begin
              bit_idx_nxt = bit_idx_r;
              phase_nxt   = PH_ST_A;
            end else begin
              shift_nxt = data_r;
              phase_nxt = PH_TX_LO;
            end
          end else if (is_read_r) begin
            stage_nxt = 2'd3;
            shift_nxt = 8'd0;
            phase_nxt = PH_RX_LO;
          end else begin
            bit_idx_nxt = bit_idx_r;
            phase_nxt   = PH_SP_LO;
          end
        end
        PH_RX_LO: phase_nxt = PH_RX_HI;
        PH_RX_HI: begin
          shift_nxt = rx_shift;
          if (bit_idx_r == 3'd7) begin
            rx_nxt    = rx_shift;
            phase_nxt = PH_NK_LO;
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            phase_nxt   = PH_RX_LO;
          end
        end
        PH_NK_LO: phase_nxt = PH_NK_HI;
        PH_NK_HI: phase_nxt = PH_SP_LO;
        PH_SP_LO: phase_nxt = PH_SP_HI;
        default: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          bad       = failed_r;
        end
      endcase
    end else begin
      delay_nxt = delay_inc;
    end
  end

  // line levels follow the phase after this tick
  always_comb begin
    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.finished  = done;
    res_nxt.status    = bad;
    res_nxt.read_byte = rx_nxt;
    case (phase_nxt)
      PH_ST_B: begin
        res_nxt.scl_level = 1'b1; res_nxt.sda_drive = 1'b0; res_nxt.sda_owned = 1'b1;
      end
      PH_TX_LO, PH_TX_TL: begin
        res_nxt.scl_level = 1'b0; res_nxt.sda_drive = shift_nxt[7];
        res_nxt.sda_owned = 1'b1;
      end
      PH_TX_HI: begin
        res_nxt.scl_level = 1'b1; res_nxt.sda_drive = shift_nxt[7];
        res_nxt.sda_owned = 1'b1;
      end
      PH_AK_LO, PH_AK_TL, PH_RX_LO: begin
        res_nxt.scl_level = 1'b0; res_nxt.sda_drive = 1'b1; res_nxt.sda_owned = 1'b0;
      end
      PH_AK_HI, PH_AK_POLL, PH_RX_HI: begin
        res_nxt.scl_level = 1'b1; res_nxt.sda_drive = 1'b1; res_nxt.sda_owned = 1'b0;
      end
      PH_NK_LO: begin
        res_nxt.scl_level = 1'b0; res_nxt.sda_drive = 1'b1; res_nxt.sda_owned = 1'b1;
      end
      PH_SP_LO: begin
        res_nxt.scl_level = 1'b0; res_nxt.sda_drive = 1'b0; res_nxt.sda_owned = 1'b1;
      end
      default: begin
        res_nxt.scl_level = 1'b1; res_nxt.sda_drive = 1'b1; res_nxt.sda_owned = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      delay_r     <= 16'd0;
      bit_idx_r   <= 3'd0;
      shift_r     <= 8'd0;
      ack_cnt_r   <= 8'd0;
      addr_r      <= 7'd0;
      reg_r       <= 8'd0;
      data_r      <= 8'd0;
      is_read_r   <= 1'b0;
      rx_r        <= 8'd0;
      stage_r     <= 2'd0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r   <= phase_nxt;
        delay_r   <= delay_nxt;
        bit_idx_r <= bit_idx_nxt;
        shift_r   <= shift_nxt;
        ack_cnt_r <= ack_cnt_nxt;
        addr_r    <= addr_nxt;
        reg_r     <= reg_nxt;
        data_r    <= data_nxt;
        is_read_r <= is_read_nxt;
        rx_r      <= rx_nxt;
        stage_r   <= stage_nxt;
        failed_r  <= failed_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/i2c_register_master.sv =====
// ----------------------------------------------------------------------------
// i2c_register_master
// I2C master for single register writes and reads, one bus tick per beat.
// ----------------------------------------------------------------------------
// a taken input beat is written into the queue, then popped by the engine and registered as a result beat
// throughput: one beat per cycle while the output is not stalled, one sequencer step per beat
// the two-entry queue between front end and engine absorbs output stalls
// reset (synchronous, rst_n low): bus idle, queue empty, half period 5,
// acknowledge timeout 250
module i2c_register_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_dev_addr,
  input  logic [7:0]  in_reg_sel,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_drive,
  output logic        out_sda_owned,
  output logic        out_busy_res,
  output logic        out_finished,
  output logic        out_status,
  output logic [7:0]  out_read_byte
);

  logic [15:0]        half_period_r;
  logic [7:0]         ack_timeout_r;
  i2crm_pkg::cfg_t    cfg;
  i2crm_pkg::item_t   q_item;
  i2crm_pkg::result_t res;
  logic               q_valid;
  logic               pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2crm_pkg::HALF_PERIOD_RESET;
      ack_timeout_r <= i2crm_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2crm_pkg::CFG_IDX_HALF_PERIOD: half_period_r <= cfg_data;
        i2crm_pkg::CFG_IDX_ACK_TIMEOUT: ack_timeout_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.half_period_ticks = half_period_r;
  assign cfg.ack_timeout       = ack_timeout_r;

  i2crm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_dev_addr   (in_dev_addr),
    .in_reg_sel    (in_reg_sel),
    .in_write_data (in_write_data),
    .in_sda_in     (in_sda_in),
    .pop           (pop),
    .q_valid       (q_valid),
    .q_item        (q_item)
  );

  i2crm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_scl_level = res.scl_level;
  assign out_sda_drive = res.sda_drive;
  assign out_sda_owned = res.sda_owned;
  assign out_busy_res  = res.busy_res;
  assign out_finished  = res.finished;
  assign out_status    = res.status;
  assign out_read_byte = res.read_byte;

  // a finishing beat leaves the bus idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_busy_res && out_scl_level && out_sda_drive)
    else $error("finish beat with bus not idle");

  // a failure is only reported on the finishing beat
  a_status_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_finished)
    else $error("status set outside finish");

  // released data line reads back high
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sda_owned |-> out_sda_drive && out_busy_res)
    else $error("released sda not high or idle");

  // engine never pops an empty queue
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ===== dv/i2c_register_master_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_register_master_tb
// Drives bus ticks and register requests into the I2C register master and
// checks every result beat against a cycle-exact model of the bus sequencer.
// A short table of directed beats comes first, then random traffic under
// several timing settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_register_master_tb;

  localparam i2crm_pkg::req_kind_t REQ_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 80;

  typedef enum logic [4:0] {
    P_IDLE, P_START_HI, P_START_LO, P_BIT_LO, P_BIT_HI, P_BIT_TAIL,
    P_ACK_LO, P_ACK_HI, P_ACK_POLL, P_ACK_TAIL, P_RX_LO, P_RX_HI,
    P_NACK_LO, P_NACK_HI, P_STOP_LO, P_STOP_HI
  } bus_phase_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               cfg_idx;
    logic [15:0]        cfg_val;
    i2crm_pkg::item_t   it;
    logic               typed;
    i2crm_pkg::result_t want;
  } dir_row_t;

  localparam i2crm_pkg::result_t LV_IDLE = '{
    scl_level: 1'b1, sda_drive: 1'b1, sda_owned: 1'b1, busy_res: 1'b0,
    finished: 1'b0, status: 1'b0, read_byte: 8'h00};
  localparam i2crm_pkg::result_t LV_START = '{
    scl_level: 1'b1, sda_drive: 1'b1, sda_owned: 1'b1, busy_res: 1'b1,
    finished: 1'b0, status: 1'b0, read_byte: 8'h00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = 2'd0;
  logic [6:0]  in_dev_addr = 7'd0;
  logic [7:0]  in_reg_sel = 8'd0;
  logic [7:0]  in_write_data = 8'd0;
  logic        in_sda_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_level;
  logic        out_sda_drive;
  logic        out_sda_owned;
  logic        out_busy_res;
  logic        out_finished;
  logic        out_status;
  logic [7:0]  out_read_byte;

  i2c_register_master DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_dev_addr   (in_dev_addr),
    .in_reg_sel    (in_reg_sel),
    .in_write_data (in_write_data),
    .in_sda_in     (in_sda_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_drive (out_sda_drive),
    .out_sda_owned (out_sda_owned),
    .out_busy_res  (out_busy_res),
    .out_finished  (out_finished),
    .out_status    (out_status),
    .out_read_byte (out_read_byte)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sequencer model state
  logic [15:0] cfg_half = i2crm_pkg::HALF_PERIOD_RESET;
  logic [7:0]  cfg_ack = i2crm_pkg::ACK_TIMEOUT_RESET;
  bus_phase_t  bus_ph = P_IDLE;
  logic [15:0] tick_cnt = 16'd0;
  logic [2:0]  bit_no = 3'd0;
  logic [7:0]  shifter = 8'd0;
  logic [7:0]  ack_polls = 8'd0;
  logic [6:0]  tgt_addr = 7'd0;
  logic [7:0]  tgt_reg = 8'd0;
  logic [7:0]  tgt_data = 8'd0;
  logic        rd_mode = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic [1:0]  byte_no = 2'd0;
  logic        aborted = 1'b0;

  i2crm_pkg::result_t levels_due[$];
  dir_row_t           dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          src_calm = 1'b0;
  bit          ack_never = 1'b0;

  int unsigned half_plan[6] = '{1, 2, 65535, 1, 3, 0};
  int unsigned ack_plan[6] = '{255, 1, 4, 0, 7, 255};
  int unsigned items_plan[6] = '{110, 110, 60, 100, 100, 100};

  task automatic load_next_byte();
    case (byte_no)
      2'd0:    shifter = {tgt_addr, 1'b0};
      2'd1:    shifter = tgt_reg;
      default: shifter = rd_mode ? {tgt_addr, 1'b1} : tgt_data;
    endcase
    bit_no = 3'd0;
    bus_ph = P_BIT_LO;
  endtask

  task automatic predict_bus_tick(input i2crm_pkg::item_t it,
                                  output i2crm_pkg::result_t lv);
    logic [15:0] h;
    logic        done;
    logic        bad;
    h = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
    done = 1'b0;
    bad = 1'b0;
    if (bus_ph == P_IDLE) begin
      if (it.kind == i2crm_pkg::REQ_WRITE || it.kind == i2crm_pkg::REQ_READ) begin
        tgt_addr = it.dev_addr;
        tgt_reg = it.reg_sel;
        tgt_data = it.write_data;
        rd_mode = (it.kind == i2crm_pkg::REQ_READ);
        byte_no = 2'd0;
        aborted = 1'b0;
        tick_cnt = 16'd0;
        bus_ph = P_START_HI;
      end
    end else if (bus_ph == P_ACK_POLL) begin
      if (!it.sda_in) begin
        tick_cnt = 16'd0;
        bus_ph = P_ACK_TAIL;
      end else if (ack_polls >= cfg_ack) begin
        aborted = 1'b1;
        tick_cnt = 16'd0;
        bus_ph = P_STOP_LO;
      end else begin
        ack_polls++;
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= h) begin
        tick_cnt = 16'd0;
        case (bus_ph)
          P_START_HI: bus_ph = P_START_LO;
          P_START_LO: load_next_byte();
          P_BIT_LO:   bus_ph = P_BIT_HI;
          P_BIT_HI:   bus_ph = P_BIT_TAIL;
          P_BIT_TAIL: begin
            shifter = {shifter[6:0], 1'b0};
            if (bit_no == 3'd7) begin
              ack_polls = 8'd0;
              bus_ph = P_ACK_LO;
            end else begin
              bit_no++;
              bus_ph = P_BIT_LO;
            end
          end
          P_ACK_LO:   bus_ph = P_ACK_HI;
          P_ACK_HI:   bus_ph = P_ACK_POLL;
          P_ACK_TAIL: begin
            if (byte_no == 2'd0) begin
              byte_no = 2'd1;
              load_next_byte();
            end else if (byte_no == 2'd1) begin
              byte_no = 2'd2;
              // a read turns the bus around with a repeated start
              if (rd_mode) bus_ph = P_START_HI;
              else load_next_byte();
            end else if (rd_mode) begin
              byte_no = 2'd3;
              bit_no = 3'd0;
              shifter = 8'd0;
              bus_ph = P_RX_LO;
            end else begin
              bus_ph = P_STOP_LO;
            end
          end
          P_RX_LO:    bus_ph = P_RX_HI;
          P_RX_HI: begin
            shifter = {shifter[6:0], it.sda_in};
            if (bit_no == 3'd7) begin
              rx_byte = shifter;
              bus_ph = P_NACK_LO;
            end else begin
              bit_no++;
              bus_ph = P_RX_LO;
            end
          end
          P_NACK_LO:  bus_ph = P_NACK_HI;
          P_NACK_HI:  bus_ph = P_STOP_LO;
          P_STOP_LO:  bus_ph = P_STOP_HI;
          default: begin
            bus_ph = P_IDLE;
            done = 1'b1;
            bad = aborted;
          end
        endcase
      end
    end

    lv = LV_IDLE;
    case (bus_ph)
      P_START_LO: lv.sda_drive = 1'b0;
      P_BIT_LO, P_BIT_TAIL: begin
        lv.scl_level = 1'b0;
        lv.sda_drive = shifter[7];
      end
      P_BIT_HI: lv.sda_drive = shifter[7];
      P_ACK_LO, P_ACK_TAIL, P_RX_LO: begin
        lv.scl_level = 1'b0;
        lv.sda_owned = 1'b0;
      end
      P_ACK_HI, P_ACK_POLL, P_RX_HI: lv.sda_owned = 1'b0;
      P_NACK_LO: lv.scl_level = 1'b0;
      P_STOP_LO: begin
        lv.scl_level = 1'b0;
        lv.sda_drive = 1'b0;
      end
      default: ;
    endcase
    lv.busy_res = (bus_ph != P_IDLE);
    lv.finished = done;
    lv.status = bad;
    lv.read_byte = rx_byte;
  endtask

  function automatic dir_row_t beat_row(i2crm_pkg::req_kind_t k, logic [6:0] a,
                                        logic [7:0] r, logic [7:0] d, logic s);
    dir_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.it = '{kind: k, dev_addr: a, reg_sel: r, write_data: d, sda_in: s};
    return row;
  endfunction

  function automatic dir_row_t seen_row(i2crm_pkg::req_kind_t k, logic [6:0] a,
                                        logic [7:0] r, logic [7:0] d, logic s,
                                        i2crm_pkg::result_t lv);
    dir_row_t row;
    row = beat_row(k, a, r, d, s);
    row.typed = 1'b1;
    row.want = lv;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [15:0] v);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_val = v;
    return row;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 18) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic send_beat(input i2crm_pkg::item_t it, input logic typed,
                           input i2crm_pkg::result_t want);
    int unsigned        gap;
    i2crm_pkg::result_t lv;
    gap = (!src_calm && $urandom_range(0, 3) == 0) ? pause_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.kind;
    in_dev_addr <= it.dev_addr;
    in_reg_sel <= it.reg_sel;
    in_write_data <= it.write_data;
    in_sda_in <= it.sda_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_bus_tick(it, lv);
    levels_due.push_back(typed ? want : lv);
  endtask

  // hold the input side until every expected beat is back, then let the engine settle
  task automatic settle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == i2crm_pkg::CFG_IDX_HALF_PERIOD) cfg_half = v;
    else cfg_ack = v[7:0];
    cfg_we <= 1'b0;
  endtask

  task automatic next_random_item(output i2crm_pkg::item_t it);
    it.dev_addr = 7'($urandom_range(0, 127));
    it.reg_sel = 8'($urandom_range(0, 255));
    it.write_data = 8'($urandom_range(0, 255));
    if (bus_ph == P_IDLE) begin
      if ($urandom_range(0, 9) < 7) begin
        it.kind = ($urandom_range(0, 1) == 1) ? i2crm_pkg::REQ_READ : i2crm_pkg::REQ_WRITE;
        ack_never = ($urandom_range(0, 9) == 0);
      end else begin
        it.kind = ($urandom_range(0, 1) == 1) ? i2crm_pkg::REQ_TICK : REQ_UNUSED;
      end
    end else begin
      it.kind = 2'($urandom_range(0, 3));
    end
    // the target answers most polls high, and every poll high if this transfer is meant to time out
    if (bus_ph == P_ACK_POLL) it.sda_in = ack_never ? 1'b1 : ($urandom_range(0, 2) != 0);
    else it.sda_in = 1'($urandom_range(0, 1));
  endtask

  initial begin : stimulus
    i2crm_pkg::item_t it;
    logic [15:0]      half;
    logic [15:0]      ack;
    int unsigned      n;
    int               p;
    int               k;
    dir_rows.push_back(seen_row(i2crm_pkg::REQ_TICK, 7'd0, 8'd0, 8'd0, 1'b0, LV_IDLE));
    dir_rows.push_back(seen_row(REQ_UNUSED, 7'd127, 8'd255, 8'd255, 1'b1, LV_IDLE));
    dir_rows.push_back(seen_row(i2crm_pkg::REQ_TICK, 7'd127, 8'd255, 8'd255, 1'b1,
                                LV_IDLE));
    dir_rows.push_back(seen_row(i2crm_pkg::REQ_WRITE, 7'd127, 8'd255, 8'd255, 1'b1,
                                LV_START));
    // requests while busy are dropped
    dir_rows.push_back(beat_row(i2crm_pkg::REQ_READ, 7'd0, 8'd0, 8'd0, 1'b0));
    dir_rows.push_back(beat_row(i2crm_pkg::REQ_WRITE, 7'd85, 8'd170, 8'd85, 1'b1));
    // half period shrinks to zero mid-phase: the phase ends on the next tick
    dir_rows.push_back(cfg_row(i2crm_pkg::CFG_IDX_HALF_PERIOD, 16'd0));
    dir_rows.push_back(beat_row(i2crm_pkg::REQ_TICK, 7'd42, 8'd0, 8'd255, 1'b0));
    for (k = 0; k < 8; k++)
      dir_rows.push_back(beat_row(REQ_UNUSED, 7'd0, 8'd255, 8'd0, 1'(k)));
    dir_rows.push_back(cfg_row(i2crm_pkg::CFG_IDX_ACK_TIMEOUT, 16'd0));
    for (k = 0; k < 7; k++)
      dir_rows.push_back(beat_row(i2crm_pkg::REQ_READ, 7'd127, 8'd0, 8'd0, 1'(k + 1)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (p = 0; p < 10; p++) begin
      settle();
      if (p < 6) begin
        half = 16'(half_plan[p]);
        ack = 16'(ack_plan[p]);
        n = items_plan[p];
      end else begin
        half = 16'($urandom_range(0, 4));
        ack = 16'($urandom_range(0, 255));
        n = 80;
      end
      write_reg(i2crm_pkg::CFG_IDX_HALF_PERIOD, half);
      write_reg(i2crm_pkg::CFG_IDX_ACK_TIMEOUT, ack);
      src_calm = ($urandom_range(0, 3) == 0);
      repeat (n) begin
        next_random_item(it);
        send_beat(it, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && levels_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side: random stalls, calm stretches, and one long hold that backs up the input
  initial begin : sink
    int unsigned stall_left;
    int unsigned cyc;
    bit          sink_calm;
    bit          long_hold_done;
    stall_left = 0;
    cyc = 0;
    sink_calm = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      // middle of a long random stretch, so the sender keeps offering beats
      if (!long_hold_done && results_seen >= 450) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !sink_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pause_len();
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin : check_results
    i2crm_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (levels_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = levels_due.pop_front();
        check_field("scl_level", 8'(out_scl_level), 8'(want.scl_level));
        check_field("sda_drive", 8'(out_sda_drive), 8'(want.sda_drive));
        check_field("sda_owned", 8'(out_sda_owned), 8'(want.sda_owned));
        check_field("busy_res", 8'(out_busy_res), 8'(want.busy_res));
        check_field("finished", 8'(out_finished), 8'(want.finished));
        check_field("status", 8'(out_status), 8'(want.status));
        check_field("read_byte", out_read_byte, want.read_byte);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
